@@ rtl/rwf_pkg.sv @@
// Package for the RGB waveform accumulator: item kinds, cell constants and
// the command and status bundles between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
package rwf_pkg;

  localparam int unsigned LevelW  = 8;   // one cell, also one display row index
  localparam int unsigned ColumnW = 10;  // width of the column field
  localparam int unsigned WidthW  = 11;  // width of the image_width register

  localparam logic [LevelW-1:0] StepUp   = 8'h0f;
  localparam logic [LevelW-1:0] CellFull = 8'hff;
  // A cell at or above this value saturates at CellFull on the next bump.
  localparam logic [LevelW-1:0] SatFloor = CellFull - StepUp;

  localparam logic [WidthW-1:0] WidthReset = 11'd1024;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } rwf_kind_e;

  typedef struct packed {
    logic accept;    // item taken: latch addresses, issue the store reads
    logic pix_wr;    // write back the bumped cells
    logic clr_wr;    // write zero at the sweep address and advance it
    logic out_load;  // move the read data into the result register
  } rwf_cmd_t;

  typedef struct packed {
    logic pix_ok;    // the offered pixel lies inside width and store
    logic clr_last;  // the sweep is at its final address
  } rwf_sts_t;

endpackage

@@ rtl/rgb_waveform_accumulator_core.sv @@
// RGB waveform accumulator, top level: 8-bit intensity stores for red,
// green and blue, indexed by display row and pixel column.
// Depends on rwf_pkg, rwf_ctrl and rwf_datapath.
//
// Usage: items enter on the in_valid_i/in_ready_o channel, one beat per
// item, with kind_i selecting pixel accumulate, clear, or read. A pixel
// beat bumps the cell at its column and at row 255 - component in each
// color store by 15, saturating at 255; a pixel at or beyond image_width
// is dropped. A read beat returns one beat on out_valid_o/out_ready_i with
// the three levels at display_row_i and column_i. Clear and pixel beats
// give no result.
// A kept pixel occupies the block through its store read and then the
// write-back through the single write port of each store. A read moves
// through the store read and the ST_READ state, and the block takes the
// next item right after, since the result sits in its own output register.
// A clear sweeps every store address, one per cycle, 256 * 2^clog2(
// MAX_COLUMNS) addresses, 262144 at the default. A dropped pixel and kind 3
// return the block to idle straight from the accept.
// Reset runs the same clearing sweep before the first item is accepted;
// image_width returns to 1024. The config register can be written at any
// time with cfg_we_i. When the receiver stalls, a finished result is held
// and a later read waits in the block until the output register frees.
module rgb_waveform_accumulator_core #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rwf_pkg::WidthW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [rwf_pkg::ColumnW-1:0] column_i,
  input  logic [rwf_pkg::LevelW-1:0]  red_i,
  input  logic [rwf_pkg::LevelW-1:0]  green_i,
  input  logic [rwf_pkg::LevelW-1:0]  blue_i,
  input  logic [rwf_pkg::LevelW-1:0]  display_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rwf_pkg::LevelW-1:0]  red_level_o,
  output logic [rwf_pkg::LevelW-1:0]  green_level_o,
  output logic [rwf_pkg::LevelW-1:0]  blue_level_o
);
  import rwf_pkg::*;

  // The controller drives commands; the datapath reports only whether the
  // offered pixel is in range and whether the clear sweep is finished.
  rwf_cmd_t cmd;
  rwf_sts_t sts;

  rwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwf_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .column_i     (column_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .display_row_i(display_row_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .red_level_o  (red_level_o),
    .green_level_o(green_level_o),
    .blue_level_o (blue_level_o)
  );

endmodule

@@ rtl/rwf_store.sv @@
// One color store of the waveform: a single-port-write, registered-read
// memory with a saturating bump of the last read cell.
// Depends on rwf_pkg.
module rwf_store #(
  parameter int unsigned AddrW = 18
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  input  logic                       wr_en_i,
  input  logic                       wr_zero_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  output logic [rwf_pkg::LevelW-1:0] level_o
);
  import rwf_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  logic [LevelW-1:0] mem_q [Depth];
  logic [LevelW-1:0] level_q;
  logic [LevelW-1:0] wr_data;

  // The write-back value is derived from the registered cell of the last read, or is zero for a clear.
  always_comb begin
    if (wr_zero_i) begin
      wr_data = '0;
    end else if (level_q >= SatFloor) begin
      wr_data = CellFull;
    end else begin
      wr_data = level_q + StepUp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      level_q <= mem_q[rd_addr_i];
    end
  end

  assign level_o = level_q;

endmodule

@@ rtl/rwf_datapath.sv @@
// Datapath of the waveform accumulator: width register, address formation,
// clear sweep counter, the three color stores and the result register.
// Depends on rwf_pkg and rwf_store.
module rwf_datapath #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rwf_pkg::WidthW-1:0]  cfg_wdata_i,
  input  logic [1:0]                  kind_i,
  input  logic [rwf_pkg::ColumnW-1:0] column_i,
  input  logic [rwf_pkg::LevelW-1:0]  red_i,
  input  logic [rwf_pkg::LevelW-1:0]  green_i,
  input  logic [rwf_pkg::LevelW-1:0]  blue_i,
  input  logic [rwf_pkg::LevelW-1:0]  display_row_i,
  input  rwf_pkg::rwf_cmd_t           cmd_i,
  output rwf_pkg::rwf_sts_t           sts_o,
  output logic [rwf_pkg::LevelW-1:0]  red_level_o,
  output logic [rwf_pkg::LevelW-1:0]  green_level_o,
  output logic [rwf_pkg::LevelW-1:0]  blue_level_o
);
  import rwf_pkg::*;

  localparam int unsigned ColW    = $clog2(MAX_COLUMNS);
  localparam int unsigned ColExtW = ((ColW > ColumnW) ? ColW : ColumnW) + 1;
  localparam int unsigned AddrW   = LevelW + ColW;
  localparam int unsigned NumCh   = 3;

  logic [WidthW-1:0]  image_width_q;
  logic [AddrW-1:0]   clr_cnt_q;
  logic [ColExtW-1:0] col_ext;
  logic               col_in_store;
  logic               oob_q;
  logic [LevelW-1:0]  comp [NumCh];
  logic [LevelW-1:0]  level [NumCh];
  logic [AddrW-1:0]   rd_addr [NumCh];
  logic [AddrW-1:0]   addr_q [NumCh];
  logic [AddrW-1:0]   wr_addr [NumCh];
  logic [LevelW-1:0]  out_q [NumCh];

  assign comp[0] = red_i;
  assign comp[1] = green_i;
  assign comp[2] = blue_i;

  assign col_ext      = ColExtW'(column_i);
  assign col_in_store = col_ext < ColExtW'(MAX_COLUMNS);

  assign sts_o.pix_ok   = col_in_store && ({1'b0, column_i} < image_width_q);
  assign sts_o.clr_last = &clr_cnt_q;

  // A pixel lands on display row 255 - component, which is the inverse.
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      if (rwf_kind_e'(kind_i) == KIND_READ) begin
        rd_addr[c] = {display_row_i, col_ext[ColW-1:0]};
      end else begin
        rd_addr[c] = {~comp[c], col_ext[ColW-1:0]};
      end
      wr_addr[c] = cmd_i.clr_wr ? clr_cnt_q : addr_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WidthReset;
      clr_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        image_width_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= rd_addr;
      oob_q  <= !col_in_store;
    end
    if (cmd_i.out_load) begin
      for (int c = 0; c < NumCh; c++) begin
        out_q[c] <= oob_q ? '0 : level[c];
      end
    end
  end

  for (genvar g = 0; g < NumCh; g++) begin : g_store
    rwf_store #(
      .AddrW(AddrW)
    ) u_store (
      .clk_i    (clk_i),
      .rd_en_i  (cmd_i.accept),
      .rd_addr_i(rd_addr[g]),
      .wr_en_i  (cmd_i.pix_wr || cmd_i.clr_wr),
      .wr_zero_i(cmd_i.clr_wr),
      .wr_addr_i(wr_addr[g]),
      .level_o  (level[g])
    );
  end

  assign red_level_o   = out_q[0];
  assign green_level_o = out_q[1];
  assign blue_level_o  = out_q[2];

endmodule

@@ rtl/rwf_ctrl.sv @@
// Controller of the waveform accumulator: sequences accept, bump, read and
// the clear sweep, and owns the result valid flag.
// Depends on rwf_pkg.
module rwf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rwf_pkg::rwf_sts_t sts_i,
  output rwf_pkg::rwf_cmd_t cmd_o
);
  import rwf_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUMP,
    ST_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.accept   = accept;
  assign cmd_o.pix_wr   = (state_q == ST_BUMP);
  assign cmd_o.clr_wr   = (state_q == ST_CLEAR);
  assign cmd_o.out_load = (state_q == ST_READ) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (rwf_kind_e'(kind_i))
              KIND_PIXEL: state_q <= sts_i.pix_ok ? ST_BUMP : ST_IDLE;
              KIND_CLEAR: state_q <= ST_CLEAR;
              KIND_READ:  state_q <= ST_READ;
              default:    state_q <= ST_IDLE;
            endcase
          end
        end
        ST_BUMP: begin
          state_q <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase

      priority if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
